// ----- hw/rtl/lfu_slot_replacement_assert.svh -----
// Assertion macros for the lfu slot replacement block.
// Used by lfu_slot_replacement.sv; no other dependencies.
// Each macro needs signals named clock and reset in the including scope.
`ifndef LFU_SLOT_REPLACEMENT_ASSERT_SVH
`define LFU_SLOT_REPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define LFUSR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfu slot replacement: check failed");

// next-cycle implication, checked outside reset
`define LFUSR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfu slot replacement: check failed");

`else

`define LFUSR_ASSERT_NOW(lbl, ante, cons)
`define LFUSR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/lfusr_pkg.sv -----
// Package for the lfu slot replacement block: field widths, codes and state type.
// No dependencies; used by lfu_slot_replacement.sv.
package lfusr_pkg;

   // fixed field widths of the request, response and register
   localparam int unsigned ID_WIDTH     = 7;
   localparam int unsigned ID_SPAN      = 2 ** ID_WIDTH;
   localparam int unsigned ACTION_WIDTH = 2;
   localparam int unsigned OCC_WIDTH    = 5;
   localparam int unsigned LIMIT_WIDTH  = 5;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 5'd16;

   // response action codes
   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_HIT     = 2'd0,
      ACT_APPEND  = 2'd1,
      ACT_REPLACE = 2'd2
   } action_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

// ----- hw/rtl/lfu_slot_replacement.sv -----
// Top level of the lfu slot replacement block: slot store, scan sequencer, response.
// Depends on lfusr_pkg and the macro header lfu_slot_replacement_assert.svh.
//
// Usage
//   A request is taken at a rising edge where start is high and busy is low;
//   req_candidate_id names the identifier referenced. The identifier is
//   reduced modulo ID_LIMIT through a constant table on the way in.
//   One compare unit then walks the held slots, one slot per cycle, looking
//   for a match and at the same time tracking the lowest count (oldest wins
//   on ties). A hit stops the walk early. The update state then updates the slots:
//   raise a count, append, or evict and close up the list in one step.
//   After accept the sequencer passes through scan (skipped for an empty set),
//   update and idle, where the response is shown; busy is high for all
//   but the last of these, and a new request may be taken in the cycle the
//   response is shown. The walk length is set by the single shared compare.
//   Each response is shown for exactly one cycle with rsp_valid; the receiver
//   cannot stall it. csr_write_en loads csr_slots_in_use, the fill limit;
//   write it only while idle; the block does not check it. Synchronous reset
//   empties the set, sets the limit to 16 and returns the sequencer to idle.
module lfu_slot_replacement #(
   parameter int unsigned SLOTS       = 16,
   parameter int unsigned ID_LIMIT    = 128,
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic [lfusr_pkg::ID_WIDTH-1:0]      req_candidate_id,
   // response
   output logic                                rsp_valid,
   output logic [lfusr_pkg::ACTION_WIDTH-1:0]  rsp_action,
   output logic [lfusr_pkg::ID_WIDTH-1:0]      rsp_evicted_id,
   output logic [lfusr_pkg::OCC_WIDTH-1:0]     rsp_occupancy,
   // configuration
   input  logic                                csr_write_en,
   input  logic [lfusr_pkg::LIMIT_WIDTH-1:0]   csr_slots_in_use
);

`include "lfu_slot_replacement_assert.svh"

   localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned FILL_W = $clog2(SLOTS + 1);
   localparam int unsigned IDW    = lfusr_pkg::ID_WIDTH;

   // identifier reduction table
   logic [IDW-1:0] id_mod_tab [lfusr_pkg::ID_SPAN];

   for (genvar g = 0; g < lfusr_pkg::ID_SPAN; g++) begin : g_mod
      localparam int unsigned MOD_VAL = g % ID_LIMIT;
      assign id_mod_tab[g] = IDW'(MOD_VAL);
   end

   // control state
   lfusr_pkg::state_type state_ff, state_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [lfusr_pkg::LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // working registers of the current request
   logic [IDW-1:0]         id_ff, id_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]       min_idx_ff, min_idx_in;
   logic [COUNT_WIDTH-1:0] min_cnt_ff, min_cnt_in;
   logic [IDW-1:0]         min_id_ff, min_id_in;

   // slot store
   logic [IDW-1:0]         ids_ff [SLOTS];
   logic [IDW-1:0]         ids_in [SLOTS];
   logic [COUNT_WIDTH-1:0] counts_ff [SLOTS];
   logic [COUNT_WIDTH-1:0] counts_in [SLOTS];

   // response payload
   lfusr_pkg::action_type             rsp_action_ff, rsp_action_in;
   logic [IDW-1:0]                    rsp_evicted_ff, rsp_evicted_in;
   logic [lfusr_pkg::OCC_WIDTH-1:0]   rsp_occ_ff, rsp_occ_in;

   // shared compare unit operands
   logic [IDW-1:0]         cur_id;
   logic [COUNT_WIDTH-1:0] cur_cnt;
   logic                   id_match;
   logic                   cnt_lower;
   logic                   scan_last;

   // effective limit: zero acts as one, above SLOTS acts as SLOTS
   logic [FILL_W-1:0]      limit_eff;
   logic [COUNT_WIDTH-1:0] hit_cnt;

   always_comb begin
      if (limit_ff == '0) begin
         limit_eff = FILL_W'(1);
      end else if (32'(limit_ff) > SLOTS) begin
         limit_eff = FILL_W'(SLOTS);
      end else begin
         limit_eff = FILL_W'(limit_ff);
      end
   end

   // scan read and compare
   assign cur_id    = ids_ff[scan_ff];
   assign cur_cnt   = counts_ff[scan_ff];
   assign id_match  = (cur_id == id_ff);
   assign cnt_lower = (cur_cnt < min_cnt_ff);
   assign scan_last = ((FILL_W'(scan_ff) + FILL_W'(1)) == fill_ff);
   assign hit_cnt   = counts_ff[hit_idx_ff];

   // next state and datapath
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      limit_in       = limit_ff;
      rsp_valid_in   = 1'b0;
      id_in          = id_ff;
      scan_in        = scan_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      min_idx_in     = min_idx_ff;
      min_cnt_in     = min_cnt_ff;
      min_id_in      = min_id_ff;
      ids_in         = ids_ff;
      counts_in      = counts_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_occ_in     = rsp_occ_ff;

      if (csr_write_en) begin
         limit_in = csr_slots_in_use;
      end

      case (state_ff)
         lfusr_pkg::ST_IDLE: begin
            if (start) begin
               id_in   = id_mod_tab[req_candidate_id];
               scan_in = '0;
               hit_in  = 1'b0;
               state_in = (fill_ff == '0) ? lfusr_pkg::ST_UPDATE : lfusr_pkg::ST_SCAN;
            end
         end
         lfusr_pkg::ST_SCAN: begin
            // one slot per cycle: match search and lowest count, oldest first
            if (id_match) begin
               hit_in     = 1'b1;
               hit_idx_in = scan_ff;
               state_in   = lfusr_pkg::ST_UPDATE;
            end else begin
               if ((scan_ff == '0) || cnt_lower) begin
                  min_idx_in = scan_ff;
                  min_cnt_in = cur_cnt;
                  min_id_in  = cur_id;
               end
               if (scan_last) begin
                  state_in = lfusr_pkg::ST_UPDATE;
               end else begin
                  scan_in = scan_ff + IDX_W'(1);
               end
            end
         end
         lfusr_pkg::ST_UPDATE: begin
            rsp_valid_in   = 1'b1;
            rsp_evicted_in = '0;
            if (hit_ff) begin
               // raise the count, saturating
               if (hit_cnt != '1) begin
                  counts_in[hit_idx_ff] = hit_cnt + COUNT_WIDTH'(1);
               end
               rsp_action_in = lfusr_pkg::ACT_HIT;
            end else if (fill_ff < limit_eff) begin
               // append into the next free slot
               ids_in[IDX_W'(fill_ff)]    = id_ff;
               counts_in[IDX_W'(fill_ff)] = COUNT_WIDTH'(1);
               fill_in       = fill_ff + FILL_W'(1);
               rsp_action_in = lfusr_pkg::ACT_APPEND;
            end else begin
               // evict the victim, close up behind it, append at the tail
               for (int j = 0; j < int'(SLOTS) - 1; j++) begin
                  if ((IDX_W'(j) >= min_idx_ff) && (FILL_W'(j + 1) < fill_ff)) begin
                     ids_in[j]    = ids_ff[j + 1];
                     counts_in[j] = counts_ff[j + 1];
                  end
               end
               ids_in[IDX_W'(fill_ff - FILL_W'(1))]    = id_ff;
               counts_in[IDX_W'(fill_ff - FILL_W'(1))] = COUNT_WIDTH'(1);
               rsp_evicted_in = min_id_ff;
               rsp_action_in  = lfusr_pkg::ACT_REPLACE;
            end
            rsp_occ_in = lfusr_pkg::OCC_WIDTH'(fill_in);
            state_in   = lfusr_pkg::ST_IDLE;
         end
         default: begin
            state_in = lfusr_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfusr_pkg::ST_IDLE;
         fill_ff      <= '0;
         limit_ff     <= lfusr_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers and slot store
   always_ff @(posedge clock) begin
      id_ff          <= id_in;
      scan_ff        <= scan_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      min_idx_ff     <= min_idx_in;
      min_cnt_ff     <= min_cnt_in;
      min_id_ff      <= min_id_in;
      ids_ff         <= ids_in;
      counts_ff      <= counts_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   // outputs
   assign busy           = (state_ff != lfusr_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_evicted_id = rsp_evicted_ff;
   assign rsp_occupancy  = rsp_occ_ff;

   // checks
   `LFUSR_ASSERT_NOW(a_fill_bound, 1'b1, (32'(fill_ff) <= SLOTS))
   `LFUSR_ASSERT_NEXT(a_accept_busy, (start && !busy), busy)
   `LFUSR_ASSERT_NOW(a_rsp_from_update, rsp_valid_ff, ($past(state_ff) == lfusr_pkg::ST_UPDATE))
   `LFUSR_ASSERT_NOW(a_append_grows, (rsp_valid_ff && (rsp_action_ff == lfusr_pkg::ACT_APPEND)), (fill_ff == FILL_W'($past(fill_ff) + FILL_W'(1))))

endmodule

// ----- sim/lfu_slot_replacement_tb.sv -----
// Self-checking testbench for lfu_slot_replacement: random and directed requests,
// an in-bench model of the lfu slot set, and field-by-field response checks.
// Depends on lfusr_pkg and the lfu_slot_replacement top level.
module lfu_slot_replacement_tb;

   localparam int unsigned SET_SLOTS  = 16;
   localparam int unsigned ID_RANGE   = 128;
   localparam int unsigned COUNT_BITS = 16;
   localparam int unsigned POOL_MAX   = 24;
   localparam int unsigned REPORT_MAX = 10;
   localparam int unsigned IDW        = lfusr_pkg::ID_WIDTH;
   localparam int unsigned LIMW       = lfusr_pkg::LIMIT_WIDTH;
   localparam int unsigned OCCW       = lfusr_pkg::OCC_WIDTH;

   // one predicted response
   typedef struct packed {
      lfusr_pkg::action_type action;
      logic [IDW-1:0]        evicted;
      logic [OCCW-1:0]       occupancy;
   } lfu_outcome_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [IDW-1:0]          req_candidate_id = '0;
   logic                    rsp_valid;
   logic [lfusr_pkg::ACTION_WIDTH-1:0] rsp_action;
   logic [IDW-1:0]          rsp_evicted_id;
   logic [OCCW-1:0]         rsp_occupancy;
   logic                    csr_write_en = 1'b0;
   logic [LIMW-1:0]         csr_slots_in_use = lfusr_pkg::LIMIT_RESET;

   // model of the slot set
   logic [IDW-1:0]          held_id [SET_SLOTS];
   logic [COUNT_BITS-1:0]   use_count [SET_SLOTS];
   int unsigned             fill_level = 0;
   logic [LIMW-1:0]         limit_setting = lfusr_pkg::LIMIT_RESET;

   logic [IDW-1:0]          pending_ids [$];
   lfu_outcome_type         predicted_outcomes [$];
   logic [IDW-1:0]          hot_ids [POOL_MAX];
   int unsigned             pool_size = 1;
   int unsigned             gap_left = 0;
   bit                      no_gaps = 1'b0;
   int unsigned             mismatches = 0;

   lfu_slot_replacement #(
      .SLOTS       (SET_SLOTS),
      .ID_LIMIT    (ID_RANGE),
      .COUNT_WIDTH (COUNT_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_candidate_id (req_candidate_id),
      .rsp_valid        (rsp_valid),
      .rsp_action       (rsp_action),
      .rsp_evicted_id   (rsp_evicted_id),
      .rsp_occupancy    (rsp_occupancy),
      .csr_write_en     (csr_write_en),
      .csr_slots_in_use (csr_slots_in_use)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // add one request at the tail of the pending list
   task automatic queue_request(input logic [IDW-1:0] id);
      pending_ids = {pending_ids, id};
   endtask

   // lookup on the model: hit, append or evict-and-close-up
   task automatic predict_lookup(input logic [IDW-1:0] id);
      lfu_outcome_type o;
      int unsigned  lim;
      int unsigned  hit_at;
      int unsigned  victim;
      int unsigned  i;
      lim = (limit_setting == 0) ? 1 :
            ((limit_setting > SET_SLOTS) ? SET_SLOTS : int'(limit_setting));
      hit_at = SET_SLOTS;
      for (i = 0; i < fill_level; i++)
         if (hit_at == SET_SLOTS && held_id[i] == id) hit_at = i;
      o.evicted = '0;
      if (hit_at < SET_SLOTS) begin
         if (use_count[hit_at] != '1)
            use_count[hit_at] = use_count[hit_at] + COUNT_BITS'(1);
         o.action = lfusr_pkg::ACT_HIT;
      end else if (fill_level < lim) begin
         held_id[fill_level] = id;
         use_count[fill_level] = COUNT_BITS'(1);
         fill_level++;
         o.action = lfusr_pkg::ACT_APPEND;
      end else begin
         // strict compare keeps the oldest among equal counts
         victim = 0;
         for (i = 1; i < fill_level; i++)
            if (use_count[i] < use_count[victim]) victim = i;
         o.evicted = held_id[victim];
         for (i = victim; i + 1 < fill_level; i++) begin
            held_id[i] = held_id[i + 1];
            use_count[i] = use_count[i + 1];
         end
         held_id[fill_level - 1] = id;
         use_count[fill_level - 1] = COUNT_BITS'(1);
         o.action = lfusr_pkg::ACT_REPLACE;
      end
      o.occupancy = fill_level[OCCW-1:0];
      predicted_outcomes = {predicted_outcomes, o};
   endtask

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_mismatch(input string field, input int unsigned want,
                                input int unsigned got);
      if (mismatches < REPORT_MAX)
         $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      mismatches++;
   endtask

   // request driver: holds start until taken, then gap or next request
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (start && busy) begin
         // request waits for the block
      end else begin
         if (start) begin
            predict_lookup(req_candidate_id);
            gap_left = no_gaps ? 0 : pick_gap();
         end
         if (gap_left == 0 && pending_ids.size() != 0) begin
            req_candidate_id <= pending_ids[0];
            pending_ids.delete(0);
            start <= 1'b1;
         end else begin
            if (gap_left != 0) gap_left--;
            start <= 1'b0;
            req_candidate_id <= IDW'($urandom_range(0, ID_RANGE - 1));
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      lfu_outcome_type o;
      if (!reset && rsp_valid) begin
         if (predicted_outcomes.size() == 0) begin
            flag_mismatch("unexpected response action", 0, rsp_action);
         end else begin
            o = predicted_outcomes[0];
            predicted_outcomes.delete(0);
            if (rsp_action !== o.action) flag_mismatch("action", o.action, rsp_action);
            if (rsp_evicted_id !== o.evicted)
               flag_mismatch("evicted_id", o.evicted, rsp_evicted_id);
            if (rsp_occupancy !== o.occupancy)
               flag_mismatch("occupancy", o.occupancy, rsp_occupancy);
         end
      end
   end

   // wait until every request is taken and every response has come
   task automatic settle();
      while (pending_ids.size() != 0 || start || predicted_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // register write, only with the block idle
   task automatic set_limit(input logic [LIMW-1:0] value);
      repeat (2) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_slots_in_use <= value;
      limit_setting = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // one random phase: a hot pool sized around the limit plus random noise
   task automatic random_phase(input logic [LIMW-1:0] value, input int unsigned n);
      int unsigned lim;
      int unsigned i;
      set_limit(value);
      lim = (value == 0) ? 1 : ((value > SET_SLOTS) ? SET_SLOTS : int'(value));
      pool_size = $urandom_range(lim, lim + 8);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      for (i = 0; i < POOL_MAX; i++) hot_ids[i] = IDW'($urandom_range(0, ID_RANGE - 1));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 80)
            queue_request(hot_ids[$urandom_range(0, pool_size - 1)]);
         else
            queue_request(IDW'($urandom_range(0, ID_RANGE - 1)));
      end
      settle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first id into an empty set, then a few hits on it back to back
      no_gaps = 1'b1;
      queue_request(7'h33);
      repeat (4) queue_request(7'h33);
      settle();
      no_gaps = 1'b0;

      // fill to a limit of three, then ties on count go to the oldest
      set_limit(5'd3);
      queue_request(7'h00);
      queue_request(7'h7f);
      queue_request(7'h55);
      queue_request(7'h2a);
      queue_request(7'h2a);
      queue_request(7'h55);
      queue_request(7'h55);
      queue_request(7'h7f);
      settle();

      // limit below the present fill: misses still evict
      set_limit(5'd1);
      queue_request(7'h01);
      queue_request(7'h01);
      queue_request(7'h7f);
      settle();

      // zero acts as one
      set_limit(5'd0);
      queue_request(7'h40);
      queue_request(7'h40);
      queue_request(7'h00);
      settle();

      // above the slot count acts as the slot count
      set_limit(5'd31);
      queue_request(7'h10);
      queue_request(7'h20);
      queue_request(7'h08);
      queue_request(7'h04);
      queue_request(7'h02);
      settle();

      // random phases over several limits, extremes among them
      random_phase(5'd5, 160);
      random_phase(5'd2, 160);
      random_phase(5'd8, 160);
      random_phase(5'd17, 160);
      random_phase(5'd12, 160);
      random_phase(5'd31, 160);
      random_phase(5'd4, 160);
      random_phase(5'd16, 160);
      random_phase(5'd0, 140);
      repeat (4) random_phase(LIMW'($urandom_range(0, 31)), 115);

      // allow for a late or stray response
      repeat (SET_SLOTS + 4) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // run limit
   initial begin
      #10000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
